// File: sv/bammt_pkg.sv
// ============================================================================
// bammt_pkg - shared definitions for the block average / min / max tracker
// Register map, reset values and the command and status bundles that run
// between the controller and the datapath.
// ============================================================================
package bammt_pkg;

  // default widths for the top-level parameters
  localparam int COUNT_BITS_DEFAULT  = 16;
  localparam int SAMPLE_BITS_DEFAULT = 32;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int WINDOW_BITS    = 16;
  localparam int CODE_BITS      = 32;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVALID_CODE  = 2'd1;

  // register reset values (invalid code is minus one in Q16.16)
  localparam logic [WINDOW_BITS-1:0]      WINDOW_RESET  = 16'd1;
  localparam logic signed [CODE_BITS-1:0] INVALID_RESET = -32'sd65536;

  // controller to datapath
  typedef struct packed {
    logic load_sample;  // capture the accepted sample
    logic update;       // min/max and block accumulation
    logic prep;         // take magnitude of the dividend
    logic div_step;     // one quotient bit
    logic load_out;     // fix sign and load result registers
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;     // final quotient bit in this cycle
  } status_t;

endpackage

// File: sv/bammt_ctrl.sv
// ============================================================================
// bammt_ctrl - sequencing controller
// Walks each accepted sample through update, divider set-up, the bit-serial
// divide and the result hand-over. Owns the result valid flag.
// ============================================================================
module bammt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output bammt_pkg::cmd_t     cmd,
  input  bammt_pkg::status_t  status
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // output register can take a new result
  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // an accepted request always goes to the update step
  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == ST_UPDATE)
    else $error("accepted request did not start an update");

  // the divider's last bit hands over to the result stage
  a_div_to_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && status.div_last |=> state == ST_EMIT)
    else $error("divider finish did not reach the result stage");

  // loading a result raises result valid
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("result loaded without result valid");

  // a finished result waits while the output register is occupied
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && result_valid && !result_ready |=> state == ST_EMIT)
    else $error("result stage left while output register was full");

endmodule

// File: sv/bammt_datapath.sv
// ============================================================================
// bammt_datapath - tracker state, radix-2 divider and result registers
// Holds the configuration, the block accumulator, min/max and the
// restoring divider that forms the block average.
// ============================================================================
module bammt_datapath #(
  parameter int COUNT_BITS  = bammt_pkg::COUNT_BITS_DEFAULT,
  parameter int SAMPLE_BITS = bammt_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bammt_pkg::cmd_t                       cmd,
  output bammt_pkg::status_t                    status,
  input  logic                                  cfg_we,
  input  logic [bammt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bammt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  output logic signed [SAMPLE_BITS-1:0]         block_average,
  output logic                                  block_done,
  output logic [COUNT_BITS-1:0]                 valid_in_block,
  output logic signed [SAMPLE_BITS-1:0]         lowest_seen,
  output logic signed [SAMPLE_BITS-1:0]         highest_seen,
  output logic [SAMPLE_BITS-1:0]                spread,
  output logic signed [SAMPLE_BITS-1:0]         midpoint
);

  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int CMP_BITS  = (SAMPLE_BITS > bammt_pkg::CODE_BITS) ?
                             SAMPLE_BITS : bammt_pkg::CODE_BITS;
  localparam int POS_BITS  = (COUNT_BITS > bammt_pkg::WINDOW_BITS) ?
                             COUNT_BITS : bammt_pkg::WINDOW_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);

  // configuration
  logic [bammt_pkg::WINDOW_BITS-1:0]      window_length;
  logic signed [bammt_pkg::CODE_BITS-1:0] invalid_code;

  // tracker state
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [COUNT_BITS-1:0]         block_position;
  logic [COUNT_BITS-1:0]         valid_count;
  logic signed [SUM_BITS-1:0]    block_sum;
  logic signed [SAMPLE_BITS-1:0] running_min;
  logic signed [SAMPLE_BITS-1:0] running_max;
  logic                          seen_any;

  // divider and pending result
  logic [SUM_BITS-1:0]   div_quo;
  logic [COUNT_BITS-1:0] div_rem;
  logic [COUNT_BITS-1:0] div_den;
  logic [STEP_BITS-1:0]  div_step;
  logic                  div_neg;
  logic                  div_zero;
  logic                  done_q;
  logic [COUNT_BITS-1:0] count_q;

  // update logic
  logic signed [CMP_BITS-1:0]    s_ext;
  logic signed [CMP_BITS-1:0]    inv_ext;
  logic                          is_valid;
  logic signed [SAMPLE_BITS-1:0] min_next;
  logic signed [SAMPLE_BITS-1:0] max_next;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic [COUNT_BITS-1:0]         count_next;
  logic [COUNT_BITS-1:0]         pos_next;
  logic [bammt_pkg::WINDOW_BITS-1:0] win_eff;
  logic                          done_next;

  // divider step and result shaping
  logic [COUNT_BITS:0]           rem_shift;
  logic [COUNT_BITS+1:0]         trial;
  logic [SUM_BITS-1:0]           quo_signed;
  logic [SAMPLE_BITS-1:0]        avg_next;
  logic signed [SAMPLE_BITS:0]   mid_total;

  // min, max and block accumulation for the captured sample
  always_comb begin
    s_ext    = CMP_BITS'(sample_q);
    inv_ext  = CMP_BITS'(invalid_code);
    is_valid = (s_ext != inv_ext);
    min_next = (!seen_any || sample_q < running_min) ? sample_q : running_min;
    max_next = (!seen_any || sample_q > running_max) ? sample_q : running_max;
    sum_next   = is_valid ? block_sum + SUM_BITS'(sample_q) : block_sum;
    count_next = is_valid ? valid_count + 1'b1 : valid_count;
    pos_next   = block_position + 1'b1;
    win_eff    = (window_length == '0) ? bammt_pkg::WINDOW_BITS'(1) : window_length;
    done_next  = (POS_BITS'(pos_next) >= POS_BITS'(win_eff));
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {div_rem, div_quo[SUM_BITS-1]};
    trial     = {1'b0, rem_shift} - {2'b00, div_den};
  end

  assign status.div_last = (div_step == STEP_LAST);

  // sign restore and result fields
  always_comb begin
    quo_signed = div_neg ? (~div_quo + 1'b1) : div_quo;
    avg_next   = div_zero ? '0 : quo_signed[SAMPLE_BITS-1:0];
    mid_total  = (SAMPLE_BITS+1)'(running_min) + (SAMPLE_BITS+1)'(running_max);
  end

  // configuration and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= bammt_pkg::WINDOW_RESET;
      invalid_code   <= bammt_pkg::INVALID_RESET;
      block_position <= '0;
      valid_count    <= '0;
      block_sum      <= '0;
      running_min    <= '0;
      running_max    <= '0;
      seen_any       <= 1'b0;
    end else begin
      if (cmd.update) begin
        running_min <= min_next;
        running_max <= max_next;
        seen_any    <= 1'b1;
        if (done_next) begin
          block_position <= '0;
          block_sum      <= '0;
          valid_count    <= '0;
        end else begin
          block_position <= pos_next;
          block_sum      <= sum_next;
          valid_count    <= count_next;
        end
      end
      // writing the window length restarts the block position
      if (cfg_we && cfg_index == bammt_pkg::REG_WINDOW_LENGTH) begin
        window_length  <= cfg_data[bammt_pkg::WINDOW_BITS-1:0];
        block_position <= '0;
      end
      if (cfg_we && cfg_index == bammt_pkg::REG_INVALID_CODE) begin
        invalid_code <= cfg_data[bammt_pkg::CODE_BITS-1:0];
      end
    end
  end

  // sample capture and divider
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_q <= sample;
    end
    if (cmd.update) begin
      div_quo  <= sum_next;
      div_den  <= count_next;
      div_zero <= (count_next == '0);
      count_q  <= count_next;
      done_q   <= done_next;
    end
    if (cmd.prep) begin
      div_neg  <= div_quo[SUM_BITS-1];
      div_quo  <= div_quo[SUM_BITS-1] ? (~div_quo + 1'b1) : div_quo;
      div_rem  <= '0;
      div_step <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[COUNT_BITS+1]) begin
        div_rem <= trial[COUNT_BITS-1:0];
      end else begin
        div_rem <= rem_shift[COUNT_BITS-1:0];
      end
      div_quo  <= {div_quo[SUM_BITS-2:0], ~trial[COUNT_BITS+1]};
      div_step <= div_step + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      block_average  <= avg_next;
      block_done     <= done_q;
      valid_in_block <= count_q;
      lowest_seen    <= running_min;
      highest_seen   <= running_max;
      spread         <= running_max - running_min;
      midpoint       <= mid_total[SAMPLE_BITS:1];
    end
  end

endmodule

// File: sv/block_average_min_max_tracker.sv
// ============================================================================
// block_average_min_max_tracker - block averaging with running min and max
// Top level: controller, datapath and the port wiring.
// ============================================================================
// Each accepted sample is processed in turn: the sample is captured, the
// accumulators are updated, the dividend magnitude is taken, the restoring
// divider forms the block average one quotient bit per cycle over the full
// SAMPLE_BITS + COUNT_BITS block sum, and the result register is loaded once
// the output register is free. A new sample is taken as soon as the previous
// one has been loaded into the result register, even if that result has not
// been collected yet.
// Configuration writes are taken at any time and should only be issued while
// the block is idle.
module block_average_min_max_tracker #(
  parameter int COUNT_BITS  = bammt_pkg::COUNT_BITS_DEFAULT,
  parameter int SAMPLE_BITS = bammt_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bammt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bammt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // sample requests
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  // result requests
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [SAMPLE_BITS-1:0]         block_average,
  output logic                                  block_done,
  output logic [COUNT_BITS-1:0]                 valid_in_block,
  output logic signed [SAMPLE_BITS-1:0]         lowest_seen,
  output logic signed [SAMPLE_BITS-1:0]         highest_seen,
  output logic [SAMPLE_BITS-1:0]                spread,
  output logic signed [SAMPLE_BITS-1:0]         midpoint
);

  bammt_pkg::cmd_t    cmd;
  bammt_pkg::status_t status;

  // registers are always writable
  assign cfg_ready = 1'b1;

  bammt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  bammt_datapath #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .block_average  (block_average),
    .block_done     (block_done),
    .valid_in_block (valid_in_block),
    .lowest_seen    (lowest_seen),
    .highest_seen   (highest_seen),
    .spread         (spread),
    .midpoint       (midpoint)
  );

endmodule

// File: dv/block_average_min_max_tracker_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// block_average_min_max_tracker_tb - self-checking bench for the tracker
// Sends signed Q16.16 samples into the block and predicts every result in
// the bench. It starts with a short directed sequence and then runs random
// phases under changing window lengths, invalid codes and handshake idling.
// Each result is compared field by field with the oldest prediction.
// ============================================================================
module block_average_min_max_tracker_tb;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 60;     // wait before the final report
  localparam int HOLD_CYCLES  = 400;
  // no register sits at this index, so writes to it must be dropped
  localparam logic [bammt_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] avg;
    logic               done;
    logic [15:0]        count;
    logic signed [31:0] lowest;
    logic signed [31:0] highest;
    logic [31:0]        spread;
    logic signed [31:0] midpoint;
  } tracker_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [bammt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [bammt_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic                      item_valid = 1'b0;
  logic                      item_ready;
  logic signed [31:0]        sample = '0;

  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [31:0]        block_average;
  logic                      block_done;
  logic [15:0]               valid_in_block;
  logic signed [31:0]        lowest_seen;
  logic signed [31:0]        highest_seen;
  logic [31:0]               spread;
  logic signed [31:0]        midpoint;

  block_average_min_max_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .block_average (block_average),
    .block_done    (block_done),
    .valid_in_block(valid_in_block),
    .lowest_seen   (lowest_seen),
    .highest_seen  (highest_seen),
    .spread        (spread),
    .midpoint      (midpoint)
  );

  always #5 clk = ~clk;

  // bench copy of the registers and tracker state
  logic [15:0]        cfg_window = bammt_pkg::WINDOW_RESET;
  logic signed [31:0] cfg_invalid = bammt_pkg::INVALID_RESET;
  logic [15:0]        pos_in_block = '0;
  logic [15:0]        valid_cnt = '0;
  logic signed [47:0] sum_acc = '0;
  logic signed [31:0] min_seen = '0;
  logic signed [31:0] max_seen = '0;
  bit                 seen_first = 1'b0;

  logic signed [31:0] sample_queue[$];
  tracker_stats_t     predicted_stats[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  int failures = 0;
  int samples_sent = 0;
  int blocks_done = 0;
  int invalid_taken = 0;
  int window_writes = 0;
  int cycle_count = 0;

  // work out the result of one accepted sample and queue it
  function automatic void track_sample(logic signed [31:0] s);
    tracker_stats_t r;
    logic [15:0]    win;
    longint         total;
    win = (cfg_window == 16'd0) ? 16'd1 : cfg_window;
    if (!seen_first) begin
      min_seen = s;
      max_seen = s;
      seen_first = 1'b1;
    end else begin
      if (s < min_seen) min_seen = s;
      if (s > max_seen) max_seen = s;
    end
    // invalid-coded samples count for min and max only
    if (s != cfg_invalid) begin
      sum_acc = sum_acc + 48'(s);
      valid_cnt = valid_cnt + 16'd1;
    end else begin
      invalid_taken++;
    end
    r.avg = '0;
    if (valid_cnt != 16'd0) r.avg = 32'(longint'(sum_acc) / longint'(valid_cnt));
    r.count = valid_cnt;
    pos_in_block = pos_in_block + 16'd1;
    r.done = (pos_in_block >= win);
    if (r.done) begin
      pos_in_block = '0;
      sum_acc = '0;
      valid_cnt = '0;
    end
    total = longint'(min_seen) + longint'(max_seen);
    r.lowest = min_seen;
    r.highest = max_seen;
    r.spread = max_seen - min_seen;
    r.midpoint = 32'(total >>> 1);
    predicted_stats.insert(predicted_stats.size(), r);
    samples_sent++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      failures++;
    end
  endfunction

  // full-range random values half the time, else small values, invalid codes or extremes
  function automatic logic signed [31:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return cfg_invalid;
    if (roll < 22) begin
      case ($urandom_range(4))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sd0;
        3: return cfg_invalid + 32'sd1;
        default: return cfg_invalid - 32'sd1;
      endcase
    end
    if (roll < 50) return 32'($urandom_range(20'hf_ffff)) - 32'sh0008_0000;
    return $urandom;
  endfunction

  // sample driver: feeds requests from the queue, idling at random
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && !item_ready)) begin
      if (item_valid) track_sample(sample);
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_valid <= 1'b1;
        sample <= sample_queue.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, taken once when requested
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compares each request with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (predicted_stats.size() == 0) begin
          $error("result with no prediction waiting: average 0x%08h", block_average);
          failures++;
        end else begin
          tracker_stats_t w;
          w = predicted_stats.pop_front();
          check_field("block_average", w.avg, block_average);
          check_field("block_done", 32'(w.done), 32'(block_done));
          check_field("valid_in_block", 32'(w.count), 32'(valid_in_block));
          check_field("lowest_seen", w.lowest, lowest_seen);
          check_field("highest_seen", w.highest, highest_seen);
          check_field("spread", w.spread, spread);
          check_field("midpoint", w.midpoint, midpoint);
          if (w.done) blocks_done++;
        end
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // wait until every request is in and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || item_valid || predicted_stats.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [bammt_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [bammt_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    // a window write restarts the block position but keeps sum and count
    if (idx == bammt_pkg::REG_WINDOW_LENGTH) begin
      cfg_window = data[15:0];
      pos_in_block = '0;
      window_writes++;
    end else if (idx == bammt_pkg::REG_INVALID_CODE) begin
      cfg_invalid = data;
    end
  endtask

  task automatic offer(logic signed [31:0] s);
    @(negedge clk);
    sample_queue.insert(sample_queue.size(), s);
  endtask

  task automatic run_phase(logic [15:0] win, logic [31:0] code, int send_pct,
                           int recv_pct, int n_items, bit hold);
    write_reg(REG_UNUSED, $urandom);
    write_reg(bammt_pkg::REG_WINDOW_LENGTH, 32'(win));
    write_reg(bammt_pkg::REG_INVALID_CODE, code);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) sample_queue.insert(sample_queue.size(), pick_sample());
    hold_req = hold;
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window of one, invalid code minus one in Q16.16; first sample seeds
    offer(32'sh0001_8000);
    offer(32'shffff_0000);
    offer(32'sh0002_0000);
    offer(32'sd0);
    offer(-32'sd1);
    offer(32'sd1);
    drain();

    // window of four, then a block made only of invalid-coded samples
    write_reg(bammt_pkg::REG_WINDOW_LENGTH, 32'd4);
    offer(32'sd5);
    offer(32'shffff_0000);
    offer(32'sh1234_5678);
    offer(-32'sd7);
    repeat (4) offer(32'shffff_0000);
    drain();

    // shorten the window mid-block; negative average truncates toward zero
    offer(-32'sd3);
    drain();
    write_reg(bammt_pkg::REG_WINDOW_LENGTH, 32'd2);
    offer(-32'sd4);
    offer(32'sd9);
    drain();

    // unknown index, zero window, most negative invalid code
    write_reg(REG_UNUSED, 32'hdead_beef);
    write_reg(bammt_pkg::REG_WINDOW_LENGTH, 32'd0);
    write_reg(bammt_pkg::REG_INVALID_CODE, 32'h8000_0000);
    offer(32'sh8000_0000);
    offer(32'sd0);
    drain();
    write_reg(bammt_pkg::REG_INVALID_CODE, 32'h7fff_ffff);
    offer(32'sh7fff_ffff);
    offer(32'sd100);
    drain();

    // random phases
    run_phase(16'd1, 32'hffff_0000, 0, 0, 200, 1'b0);
    run_phase(16'd8, $urandom, 65, 0, 250, 1'b0);
    run_phase(16'd65535, 32'h8000_0000, 0, 65, 250, 1'b1);
    run_phase(16'd0, 32'h7fff_ffff, 8, 8, 200, 1'b0);
    run_phase(16'd3, 32'h0000_0000, 0, 0, 250, 1'b0);
    run_phase(16'($urandom_range(40, 2)), $urandom, 65, 0, 250, 1'b0);
    run_phase(16'd16, 32'hffff_0000, 0, 65, 250, 1'b0);
    run_phase(16'd5, $urandom, 8, 8, 200, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d samples over %0d window settings and %0d finished blocks;",
             samples_sent, window_writes, blocks_done);
    $display("%0d samples carried the invalid code, %0d mismatches seen.",
             invalid_taken, failures);
    if (failures == 0 && predicted_stats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: block_average_min_max_tracker.f
sv/bammt_pkg.sv
sv/bammt_ctrl.sv
sv/bammt_datapath.sv
sv/block_average_min_max_tracker.sv
dv/block_average_min_max_tracker_tb.sv
